FILE: sv/bit_pkg.sv
// Package for the binary image thinning block: sizes, codes and templates.
package bit_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned TemplateCount = 8;
  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned YW = $clog2(MaxHeight);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned PW = AW + 1;
  localparam int unsigned TW = $clog2(TemplateCount);

  localparam logic [7:0] Foreground = 8'hFF;

  localparam logic [0:0] ReqLoad = 1'b0;
  localparam logic [0:0] ReqRead = 1'b1;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  // Two bits per cell: bit 1 set is don't care, otherwise bit 0 is the wanted value.
  typedef logic [1:0] tcell_t;
  typedef tcell_t [8:0] tmpl_t;

  function automatic tmpl_t mk(input int unsigned a0, a1, a2, a3, a4, a5, a6, a7, a8);
    tmpl_t r;
    r[0] = tcell_t'(a0); r[1] = tcell_t'(a1); r[2] = tcell_t'(a2);
    r[3] = tcell_t'(a3); r[4] = tcell_t'(a4); r[5] = tcell_t'(a5);
    r[6] = tcell_t'(a6); r[7] = tcell_t'(a7); r[8] = tcell_t'(a8);
    return r;
  endfunction

  function automatic tmpl_t get_tmpl(input logic [TW-1:0] t);
    tmpl_t r;
    case (t)
      3'd0: r = mk(0, 0, 2, 0, 1, 1, 2, 1, 2);
      3'd1: r = mk(0, 0, 0, 2, 1, 2, 1, 1, 2);
      3'd2: r = mk(2, 0, 0, 1, 1, 0, 2, 1, 2);
      3'd3: r = mk(1, 2, 0, 1, 1, 0, 2, 2, 0);
      3'd4: r = mk(2, 1, 2, 1, 1, 0, 2, 0, 0);
      3'd5: r = mk(2, 1, 1, 2, 1, 2, 0, 0, 0);
      3'd6: r = mk(2, 1, 2, 0, 1, 1, 0, 0, 2);
      3'd7: r = mk(0, 2, 2, 0, 1, 1, 0, 2, 1);
      default: r = mk(2, 2, 2, 2, 2, 2, 2, 2, 2);
    endcase
    return r;
  endfunction

  function automatic logic [8:0] clamp_dim(input logic [8:0] v, input int unsigned mx);
    if (v == 9'd0) return 9'd1;
    if (32'(v) > mx) return 9'(mx);
    return v;
  endfunction

endpackage

FILE: sv/bit_store.sv
// Image store: one write port and one registered read port.
module bit_store (
  input  logic                   clk,
  input  logic                   we,
  input  logic [bit_pkg::AW-1:0] waddr,
  input  logic [7:0]             wdata,
  input  logic [bit_pkg::AW-1:0] raddr,
  output logic [7:0]             rdata
);
  logic [7:0] mem [bit_pkg::MaxWidth*bit_pkg::MaxHeight];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/binary_image_thinning.sv
// Top level of the binary image thinning block.
//
// Channel  Direction  Handshake                Payload
// in_      input      start & !busy            in_req_type, in_pixel_in, in_last_pixel
// out_     output     out_valid, one cycle     out_pixel_out, out_last_out
// cfg_     input      cfg_valid & cfg_ready    cfg_index, cfg_data
//
// A load is written when accepted unless the image is full. A read keeps busy high while
// in S_RD_OUT, and its result is on the output ports in the cycle after that.
// Thinning after the last pixel reads the store through its single read port: S_CTR and
// S_CTR_CHK check the center, a foreground center checks each needed neighbor in S_NB and
// S_NB_CHK, then S_NEXT; eight scans per round until a round removes nothing.
// Reset is synchronous and active low and clears the control state; the store is not
// cleared. The receiver cannot stall results.
module binary_image_thinning (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [0:0] in_req_type,
  input  logic [7:0] in_pixel_in,
  input  logic [0:0] in_last_pixel,
  output logic       out_valid,
  output logic [7:0] out_pixel_out,
  output logic [0:0] out_last_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [8:0] cfg_data
);
  localparam int unsigned AW = bit_pkg::AW;
  localparam int unsigned PW = bit_pkg::PW;
  localparam int unsigned TW = bit_pkg::TW;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_OUT, S_CTR, S_CTR_CHK, S_NB, S_NB_CHK, S_NEXT
  } state_t;

  state_t         state_r;
  logic [8:0]     wreg_r, hreg_r;
  logic [PW-1:0]  load_pos_r, read_pos_r;
  logic           removed_r;
  logic [8:0]     x_r, y_r;
  logic [TW-1:0]  t_r;
  logic [3:0]     k_r;
  logic           last_r;

  logic [8:0]     w, h;
  logic [PW-1:0]  size;
  logic [PW-1:0]  rd_eff;
  logic           in_acc;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [7:0]     wdata, rdata;

  bit_pkg::tmpl_t tm;
  logic [9:0]     nx, ny;
  logic [3:0]     k_next;

  assign w      = bit_pkg::clamp_dim(wreg_r, bit_pkg::MaxWidth);
  assign h      = bit_pkg::clamp_dim(hreg_r, bit_pkg::MaxHeight);
  assign size   = PW'(w) * PW'(h);
  assign rd_eff = (read_pos_r >= size) ? '0 : read_pos_r;
  assign busy   = (state_r != S_IDLE);
  assign in_acc = start && !busy;
  assign cfg_ready = !busy;
  assign tm     = bit_pkg::get_tmpl(t_r);

  // Column and row of a cell within the 3x3 window, cells numbered in raster order.
  function automatic logic [1:0] col_of(input logic [3:0] k);
    if (k inside {4'd0, 4'd3, 4'd6}) return 2'd0;
    if (k inside {4'd1, 4'd4, 4'd7}) return 2'd1;
    return 2'd2;
  endfunction

  function automatic logic [1:0] row_of(input logic [3:0] k);
    if (k < 4'd3) return 2'd0;
    if (k < 4'd6) return 2'd1;
    return 2'd2;
  endfunction

  // Skip don't-care cells and cells outside the image, always keeping the center cell.
  function automatic logic cell_needed(input logic [3:0] k, input bit_pkg::tmpl_t tp,
                                       input logic [8:0] cx, input logic [8:0] cy,
                                       input logic [8:0] ww, input logic [8:0] hh);
    logic [9:0] xx, yy;
    xx = 10'(cx) + 10'(col_of(k)) - 10'd1;
    yy = 10'(cy) + 10'(row_of(k)) - 10'd1;
    if (k > 4'd8) return 1'b0;
    if (tp[k][1]) return 1'b0;
    if (xx[9] || yy[9]) return 1'b0;
    if (xx >= 10'(ww) || yy >= 10'(hh)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [3:0] next_cell(input logic [3:0] from, input bit_pkg::tmpl_t tp,
                                           input logic [8:0] cx, input logic [8:0] cy,
                                           input logic [8:0] ww, input logic [8:0] hh);
    logic [3:0] r;
    r = 4'd9;
    for (int i = 8; i >= 0; i--) begin
      if (4'(i) >= from && 4'(i) != 4'd4 && cell_needed(4'(i), tp, cx, cy, ww, hh)) begin
        r = 4'(i);
      end
    end
    return r;
  endfunction

  assign nx = 10'(x_r) + 10'(col_of(k_r)) - 10'd1;
  assign ny = 10'(y_r) + 10'(row_of(k_r)) - 10'd1;
  assign k_next = next_cell(k_r + 4'd1, tm, x_r, y_r, w, h);

  function automatic logic [AW-1:0] addr_of(input logic [9:0] xx, input logic [9:0] yy,
                                            input logic [8:0] ww);
    return AW'(32'(yy) * 32'(ww) + 32'(xx));
  endfunction

  always_comb begin
    we    = 1'b0;
    waddr = load_pos_r[AW-1:0];
    wdata = in_pixel_in;
    raddr = addr_of(nx, ny, w);
    if (in_acc && in_req_type == bit_pkg::ReqLoad && load_pos_r < size) begin
      we = 1'b1;
    end else if (state_r == S_NB_CHK && ((rdata == bit_pkg::Foreground) != tm[k_r][0])) begin
      we = 1'b0;
    end else if (state_r == S_NEXT && last_r) begin
      we    = 1'b1;
      waddr = addr_of(10'(x_r), 10'(y_r), w);
      wdata = 8'd0;
    end
    if (state_r == S_IDLE) begin
      raddr = rd_eff[AW-1:0];
    end
  end

  bit_store u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // last_r doubles as the "all cells matched" flag while thinning.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      wreg_r     <= 9'd256;
      hreg_r     <= 9'd256;
      load_pos_r <= '0;
      read_pos_r <= '0;
      removed_r  <= 1'b0;
      out_valid  <= 1'b0;
      x_r <= '0; y_r <= '0; t_r <= '0; k_r <= '0; last_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bit_pkg::RegWidth) wreg_r <= cfg_data;
        else hreg_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_req_type == bit_pkg::ReqLoad) begin
              if (load_pos_r < size) load_pos_r <= load_pos_r + PW'(1);
              else load_pos_r <= size;
              if (in_last_pixel[0]) begin
                x_r <= '0; y_r <= '0; t_r <= '0; removed_r <= 1'b0;
                k_r <= 4'd4;
                state_r <= S_CTR;
              end
            end else begin
              last_r  <= (rd_eff == size - PW'(1));
              read_pos_r <= (rd_eff + PW'(1) >= size) ? PW'(0) : rd_eff + PW'(1);
              state_r <= S_RD_OUT;
            end
          end
        end
        S_RD_OUT: begin
          out_valid     <= 1'b1;
          out_pixel_out <= rdata;
          out_last_out  <= last_r;
          state_r       <= S_IDLE;
        end
        S_CTR: state_r <= S_CTR_CHK;
        S_CTR_CHK: begin
          if (rdata == bit_pkg::Foreground) begin
            last_r  <= 1'b1;
            k_r     <= next_cell(4'd0, tm, x_r, y_r, w, h);
            state_r <= (next_cell(4'd0, tm, x_r, y_r, w, h) == 4'd9) ? S_NEXT : S_NB;
          end else begin
            last_r  <= 1'b0;
            state_r <= S_NEXT;
          end
        end
        S_NB: state_r <= S_NB_CHK;
        S_NB_CHK: begin
          if ((rdata == bit_pkg::Foreground) != tm[k_r][0]) begin
            last_r  <= 1'b0;
            state_r <= S_NEXT;
          end else if (k_next == 4'd9) begin
            state_r <= S_NEXT;
          end else begin
            k_r     <= k_next;
            state_r <= S_NB;
          end
        end
        S_NEXT: begin
          if (last_r) removed_r <= 1'b1;
          last_r <= 1'b0;
          k_r    <= 4'd4;
          state_r <= S_CTR;
          if (x_r + 9'd1 < w) begin
            x_r <= x_r + 9'd1;
          end else begin
            x_r <= '0;
            if (y_r + 9'd1 < h) begin
              y_r <= y_r + 9'd1;
            end else begin
              y_r <= '0;
              t_r <= t_r + TW'(1);
              if (t_r == TW'(bit_pkg::TemplateCount - 1)) begin
                removed_r <= 1'b0;
                if (!(removed_r || last_r)) begin
                  load_pos_r <= '0;
                  read_pos_r <= '0;
                  state_r    <= S_IDLE;
                end
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_result_only_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_RD_OUT) else $error("stray result");
  a_no_cfg_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cfg_ready) else $error("config open while busy");
  a_load_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    load_pos_r <= PW'(bit_pkg::MaxWidth * bit_pkg::MaxHeight)) else $error("load position");
  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_OUT) |-> !we) else $error("write during read");
endmodule
